[src/led_driver_serial_write_unit_defines.svh]
// assertion macros for the led driver serial write unit
// used by the sequencer and the top level
`ifndef LED_DRIVER_SERIAL_WRITE_UNIT_DEFINES_SVH
`define LED_DRIVER_SERIAL_WRITE_UNIT_DEFINES_SVH

`ifndef SYNTH
// checked only while reset is released
`define LDS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lds check failed");
// checked during reset as well
`define LDS_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("lds check failed");
`else
`define LDS_ASSERT(name, clk, rst_n, prop)
`define LDS_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

[src/lds_pkg.sv]
// shared types, constants and helper functions of the led driver serial write unit
// no dependencies
`timescale 1ns / 1ps

package lds_pkg;

    localparam int WAIT_BITS = 10;
    localparam int WAIT_MAX  = (1 << WAIT_BITS) - 1;

    localparam int SHORT_W = 8;
    localparam int LONG_W  = 10;
    localparam int BYTE_W  = 8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_SHORT_WAIT = 2'd0;
    localparam logic [1:0] REG_LONG_WAIT  = 2'd1;
    localparam logic [1:0] REG_MODE_CMD   = 2'd2;
    localparam logic [1:0] REG_DISP_CMD   = 2'd3;

    localparam logic [SHORT_W-1:0] SHORT_WAIT_RST = 8'd3;
    localparam logic [LONG_W-1:0]  LONG_WAIT_RST  = 10'd10;
    localparam logic [BYTE_W-1:0]  MODE_CMD_RST   = 8'h44;
    localparam logic [BYTE_W-1:0]  DISP_CMD_RST   = 8'h8C;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic [SHORT_W-1:0] short_wait;
        logic [LONG_W-1:0]  long_wait;
        logic [BYTE_W-1:0]  mode_command;
        logic [BYTE_W-1:0]  display_command;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] seg_data;
        logic [BYTE_W-1:0] grid_addr;
        logic              req_type;
    } item_t;

    // clock_pin in the lowest bit
    typedef struct packed {
        logic refused;
        logic done_res;
        logic busy_res;
        logic data_pin;
        logic clock_pin;
    } res_t;

    localparam int RES_W   = $bits(res_t);
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

    // zero counts as one tick, too large saturates
    function automatic logic [WAIT_BITS-1:0] eff_wait(input logic [LONG_W-1:0] v);
        logic [WAIT_BITS-1:0] r;
        if (v == '0) begin
            r = WAIT_BITS'(1);
        end else if (int'(v) > WAIT_MAX) begin
            r = WAIT_BITS'(WAIT_MAX);
        end else begin
            r = WAIT_BITS'(v);
        end
        return r;
    endfunction

endpackage

[src/led_driver_serial_write_unit.sv]
// path: a word accepted into the input register gives its result word via the result register
// throughput: one word per cycle unless m_tready stalls; sequencer state moves only on a step
// reset: synchronous active-low aresetn, lines released high, sequencer idle,
// registers back to their reset values, both pipeline stages empty
// top level: input register, sequencer, result register, apb registers
`timescale 1ns / 1ps
`include "led_driver_serial_write_unit_defines.svh"

module led_driver_serial_write_unit import lds_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*BYTE_W-1:0]   s_tdata,   // grid_addr, seg_data
    input  logic                  s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // clock_pin, data_pin, busy_res, done_res, refused
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t  cfg;
    item_t in_reg;
    logic  in_vld_reg;
    res_t  res_next, res_reg;
    logic  out_vld_reg;
    logic  out_ready;
    logic  step_en;

    assign out_ready = !out_vld_reg || m_tready;
    assign step_en   = in_vld_reg && out_ready;
    assign s_tready  = !in_vld_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.req_type  <= s_tuser;
            in_reg.grid_addr <= s_tdata[BYTE_W-1:0];
            in_reg.seg_data  <= s_tdata[2*BYTE_W-1:BYTE_W];
        end
        if (step_en) begin
            res_reg <= res_next;
        end
    end

    lds_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lds_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (step_en),
        .item    (in_reg),
        .cfg     (cfg),
        .res     (res_next)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = TDATA_W'(res_reg);

    `LDS_ASSERT(a_stalled_item_kept, aclk, aresetn, (in_vld_reg && !out_ready) |=> in_vld_reg)
    `LDS_ASSERT(a_step_gives_result, aclk, aresetn, step_en |=> out_vld_reg)
    `LDS_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> (!in_vld_reg && !out_vld_reg))

endmodule

[src/lds_apb_regs.sv]
// apb configuration registers: wait lengths and the two command bytes
// depends on lds_pkg
`timescale 1ns / 1ps

module lds_apb_regs import lds_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_wait      <= SHORT_WAIT_RST;
            cfg_reg.long_wait       <= LONG_WAIT_RST;
            cfg_reg.mode_command    <= MODE_CMD_RST;
            cfg_reg.display_command <= DISP_CMD_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_SHORT_WAIT: cfg_reg.short_wait      <= pwdata[SHORT_W-1:0];
                REG_LONG_WAIT:  cfg_reg.long_wait       <= pwdata[LONG_W-1:0];
                REG_MODE_CMD:   cfg_reg.mode_command    <= pwdata[BYTE_W-1:0];
                REG_DISP_CMD:   cfg_reg.display_command <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SHORT_WAIT: prdata = APB_DATA_W'(cfg_reg.short_wait);
            REG_LONG_WAIT:  prdata = APB_DATA_W'(cfg_reg.long_wait);
            REG_MODE_CMD:   prdata = APB_DATA_W'(cfg_reg.mode_command);
            REG_DISP_CMD:   prdata = APB_DATA_W'(cfg_reg.display_command);
            default:        prdata = '0;
        endcase
    end

endmodule

[src/lds_sequencer.sv]
// frame sequencer: start, bytes lsb first with dummy ack clock, stop, three frames
// depends on lds_pkg and the defines header
`timescale 1ns / 1ps
`include "led_driver_serial_write_unit_defines.svh"

module lds_sequencer import lds_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_S0, ST_S1, ST_S2, ST_BPRE, ST_BLOW, ST_BHIGH,
        ST_A0, ST_A1, ST_A2, ST_A3, ST_P0, ST_P1, ST_P2
    } step_t;

    step_t                step_reg, step_next;
    logic [WAIT_BITS-1:0] wait_reg, wait_next, wait_dec;
    logic [2:0]           bit_reg, bit_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic [1:0]           frame_reg, frame_next;
    logic                 byte_reg, byte_next;
    logic [BYTE_W-1:0]    addr_reg, addr_next;
    logic [BYTE_W-1:0]    data_reg, data_next;
    logic                 clk_lvl_reg, clk_lvl_next;
    logic                 dat_lvl_reg, dat_lvl_next;
    logic                 busy_reg, busy_next;
    logic                 done, refused;
    logic [WAIT_BITS-1:0] sw, lw;
    logic [BYTE_W-1:0]    pick;

    assign sw = eff_wait(LONG_W'(cfg.short_wait));
    assign lw = eff_wait(cfg.long_wait);

    // byte_reg is still zero when a frame's first byte is loaded
    always_comb begin
        if (frame_reg == 2'd0) begin
            pick = cfg.mode_command;
        end else if (frame_reg == 2'd1) begin
            pick = byte_reg ? data_reg : addr_reg;
        end else begin
            pick = cfg.display_command;
        end
    end

    assign wait_dec = (wait_reg != '0) ? wait_reg - WAIT_BITS'(1) : wait_reg;

    always_comb begin
        step_next    = step_reg;
        wait_next    = wait_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        frame_next   = frame_reg;
        byte_next    = byte_reg;
        addr_next    = addr_reg;
        data_next    = data_reg;
        clk_lvl_next = clk_lvl_reg;
        dat_lvl_next = dat_lvl_reg;
        busy_next    = busy_reg;
        done         = 1'b0;
        refused      = 1'b0;
        if (en) begin
            if (item.req_type == REQ_WRITE) begin
                if (busy_reg) begin
                    refused = 1'b1;
                end else begin
                    addr_next    = item.grid_addr;
                    data_next    = item.seg_data;
                    busy_next    = 1'b1;
                    frame_next   = 2'd0;
                    byte_next    = 1'b0;
                    bit_next     = 3'd0;
                    step_next    = ST_S0;
                    dat_lvl_next = 1'b1;
                    wait_next    = sw;
                end
            end else if (busy_reg) begin
                wait_next = wait_dec;
                if (wait_dec == '0) begin
                    case (step_reg)
                        ST_S0: begin
                            step_next    = ST_S1;
                            clk_lvl_next = 1'b1;
                            wait_next    = lw;
                        end
                        ST_S1: begin
                            step_next    = ST_S2;
                            dat_lvl_next = 1'b0;
                            wait_next    = lw;
                        end
                        ST_S2: begin
                            step_next  = ST_BPRE;
                            shift_next = pick;
                            bit_next   = 3'd0;
                            wait_next  = sw;
                        end
                        ST_BPRE: begin
                            step_next    = ST_BLOW;
                            clk_lvl_next = 1'b0;
                            dat_lvl_next = shift_reg[0];
                            wait_next    = sw;
                        end
                        ST_BLOW: begin
                            step_next    = ST_BHIGH;
                            clk_lvl_next = 1'b1;
                            wait_next    = sw;
                        end
                        ST_BHIGH: begin
                            shift_next   = shift_reg >> 1;
                            clk_lvl_next = 1'b0;
                            wait_next    = sw;
                            if (bit_reg == 3'd7) begin
                                bit_next  = 3'd0;
                                step_next = ST_A0;
                            end else begin
                                bit_next     = bit_reg + 3'd1;
                                step_next    = ST_BLOW;
                                dat_lvl_next = shift_reg[1];
                            end
                        end
                        ST_A0: begin
                            step_next    = ST_A1;
                            dat_lvl_next = 1'b0;
                            wait_next    = sw;
                        end
                        ST_A1: begin
                            step_next    = ST_A2;
                            clk_lvl_next = 1'b1;
                            wait_next    = sw;
                        end
                        ST_A2: begin
                            step_next    = ST_A3;
                            clk_lvl_next = 1'b0;
                            wait_next    = sw;
                        end
                        // at the end of the ack the data line is set for the next byte or the stop, then a short wait
                        ST_A3: begin
                            wait_next = sw;
                            if (frame_reg == 2'd1 && !byte_reg) begin
                                byte_next    = 1'b1;
                                step_next    = ST_BPRE;
                                dat_lvl_next = 1'b1;
                                shift_next   = data_reg;
                                bit_next     = 3'd0;
                            end else begin
                                step_next    = ST_P0;
                                dat_lvl_next = 1'b0;
                            end
                        end
                        ST_P0: begin
                            step_next    = ST_P1;
                            clk_lvl_next = 1'b1;
                            wait_next    = lw;
                        end
                        ST_P1: begin
                            step_next    = ST_P2;
                            dat_lvl_next = 1'b1;
                            wait_next    = lw;
                        end
                        ST_P2: begin
                            if (frame_reg < 2'd2) begin
                                frame_next   = frame_reg + 2'd1;
                                byte_next    = 1'b0;
                                step_next    = ST_S0;
                                dat_lvl_next = 1'b1;
                                wait_next    = sw;
                            end else begin
                                step_next = ST_IDLE;
                                busy_next = 1'b0;
                                done      = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= ST_IDLE;
            wait_reg    <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            frame_reg   <= '0;
            byte_reg    <= 1'b0;
            addr_reg    <= '0;
            data_reg    <= '0;
            clk_lvl_reg <= 1'b1;
            dat_lvl_reg <= 1'b1;
            busy_reg    <= 1'b0;
        end else begin
            step_reg    <= step_next;
            wait_reg    <= wait_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            frame_reg   <= frame_next;
            byte_reg    <= byte_next;
            addr_reg    <= addr_next;
            data_reg    <= data_next;
            clk_lvl_reg <= clk_lvl_next;
            dat_lvl_reg <= dat_lvl_next;
            busy_reg    <= busy_next;
        end
    end

    always_comb begin
        res.clock_pin = clk_lvl_next;
        res.data_pin  = dat_lvl_next;
        res.busy_res  = busy_next;
        res.done_res  = done;
        res.refused   = refused;
    end

    `LDS_ASSERT(a_done_ends_busy, aclk, aresetn, res.done_res |=> !busy_reg)
    `LDS_ASSERT(a_refused_only_busy, aclk, aresetn, res.refused |-> busy_reg)
    `LDS_ASSERT(a_busy_has_wait, aclk, aresetn, busy_reg |-> (wait_reg != '0))
    `LDS_ASSERT(a_idle_matches_busy, aclk, aresetn, busy_reg == (step_reg != ST_IDLE))

endmodule
